FILE: rtl/bpla_pkg.sv
// ----------------------------------------------------------------------------
// bpla_pkg
// Shared types and constants for the button lockout / auto-repeat block.
// ----------------------------------------------------------------------------
package bpla_pkg;

  localparam int NUM_KEYS    = 9;
  localparam int REPEAT_KEYS = 4;
  localparam int RPT_COUNT   = (REPEAT_KEYS < NUM_KEYS) ? REPEAT_KEYS : NUM_KEYS;

  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

  localparam logic [TIME_W-1:0] LOCKOUT_RESET         = 32'd20000;
  localparam logic [TIME_W-1:0] REPEAT_DELAY_RESET    = 32'd400000;
  localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RESET = 32'd90000;

  typedef struct packed {
    logic [TIME_W-1:0] lockout_us;
    logic [TIME_W-1:0] repeat_delay_us;
    logic [TIME_W-1:0] repeat_interval_us;
  } cfg_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] pressed_now;
    logic [TIME_W-1:0]   now_us;
  } in_item_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] held;
    logic [NUM_KEYS-1:0] press_edges;
  } out_item_t;

endpackage

FILE: rtl/bpla_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpla_cfg_regs
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bpla_cfg_regs
  import bpla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_us         <= LOCKOUT_RESET;
      cfg.repeat_delay_us    <= REPEAT_DELAY_RESET;
      cfg.repeat_interval_us <= REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCKOUT:         cfg.lockout_us         <= cfg_wdata;
        REG_REPEAT_DELAY:    cfg.repeat_delay_us    <= cfg_wdata;
        REG_REPEAT_INTERVAL: cfg.repeat_interval_us <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/bpla_lock_lane.sv
// ----------------------------------------------------------------------------
// bpla_lock_lane
// Per-button press lockout: accepts a rising edge only after the lockout time.
// ----------------------------------------------------------------------------
module bpla_lock_lane
  import bpla_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic              first,
  input  logic              rise,
  input  logic [TIME_W-1:0] now_us,
  input  logic [TIME_W-1:0] lockout_us,
  output logic              press
);

  logic [TIME_W-1:0] last_press_time;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_us - last_press_time;
  assign press   = !first && rise && (elapsed >= lockout_us);

  always_ff @(posedge clk) begin
    if (en) begin
      if (first) begin
        last_press_time <= now_us - lockout_us;
      end else if (press) begin
        last_press_time <= now_us;
      end
    end
  end

endmodule

FILE: rtl/bpla_rpt_lane.sv
// ----------------------------------------------------------------------------
// bpla_rpt_lane
// Per-button auto-repeat deadline; a deadline of zero means disarmed.
// ----------------------------------------------------------------------------
module bpla_rpt_lane
  import bpla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              first,
  input  logic              press,
  input  logic              held,
  input  logic [TIME_W-1:0] now_us,
  input  logic [TIME_W-1:0] repeat_delay_us,
  input  logic [TIME_W-1:0] repeat_interval_us,
  output logic              rpt
);

  logic [TIME_W-1:0] repeat_due_time;
  logic [TIME_W-1:0] repeat_due_time_next;
  logic [TIME_W-1:0] due_armed;
  logic [TIME_W-1:0] late;

  // a fresh press arms the deadline before the due check of the same poll
  assign due_armed = press ? (now_us + repeat_delay_us) : repeat_due_time;
  assign late      = now_us - due_armed;
  assign rpt       = !first && held && (due_armed != '0) && !late[TIME_W-1];

  always_comb begin
    if (first || !held) begin
      repeat_due_time_next = '0;
    end else if (rpt) begin
      repeat_due_time_next = now_us + repeat_interval_us;
    end else begin
      repeat_due_time_next = due_armed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_due_time <= '0;
    end else if (en) begin
      repeat_due_time <= repeat_due_time_next;
    end
  end

endmodule

FILE: rtl/button_press_lockout_autorepeat.sv
// ----------------------------------------------------------------------------
// button_press_lockout_autorepeat
// Button poll processing: held mask, press lockout and typematic auto-repeat.
// ----------------------------------------------------------------------------
//   channel  signals                          payload
//   in       in_valid / in_ready / in_data    pressed_now, now_us
//   out      out_valid / out_ready / out_data held, press_edges
//   cfg      cfg_we / cfg_index / cfg_wdata   lockout, repeat delay, interval
//
// one poll is accepted per cycle while in_ready is high; its result appears
// in the output register on the next cycle. the per-button subtract/compare
// lanes are combinational and feed that register. in_ready drops only while
// a result waits and out_ready is low. sync reset clears the repeat deadlines
// and previous sample, sets the first-poll flag; the first poll flags no edges.
// ----------------------------------------------------------------------------
module button_press_lockout_autorepeat
  import bpla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_wdata
);

  cfg_t                cfg;
  logic                accept;
  logic                first_poll;
  logic [NUM_KEYS-1:0] prev_pressed;
  logic [NUM_KEYS-1:0] rising;
  logic [NUM_KEYS-1:0] press;
  logic [NUM_KEYS-1:0] rpt;

  bpla_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign rising   = in_data.pressed_now & ~prev_pressed;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    bpla_lock_lane u_lock (
      .clk        (clk),
      .en         (accept),
      .first      (first_poll),
      .rise       (rising[i]),
      .now_us     (in_data.now_us),
      .lockout_us (cfg.lockout_us),
      .press      (press[i])
    );

    if (i < RPT_COUNT) begin : g_rpt
      bpla_rpt_lane u_rpt (
        .clk                (clk),
        .rst                (rst),
        .en                 (accept),
        .first              (first_poll),
        .press              (press[i]),
        .held               (in_data.pressed_now[i]),
        .now_us             (in_data.now_us),
        .repeat_delay_us    (cfg.repeat_delay_us),
        .repeat_interval_us (cfg.repeat_interval_us),
        .rpt                (rpt[i])
      );
    end else begin : g_no_rpt
      assign rpt[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_poll   <= 1'b1;
      prev_pressed <= '0;
    end else if (accept) begin
      first_poll   <= 1'b0;
      prev_pressed <= in_data.pressed_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.held        <= in_data.pressed_now;
      out_data.press_edges <= press | rpt;
    end
  end

endmodule
